### src/adaptive_interrupt_rate_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive interrupt rate core
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_INTERRUPT_RATE_CORE_MACROS_SVH
`define ADAPTIVE_INTERRUPT_RATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define AIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("adaptive_interrupt_rate_core: same-cycle check failed");

// next-cycle implication
`define AIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("adaptive_interrupt_rate_core: next-cycle check failed");

`else

`define AIR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AIR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### src/air_pkg.sv
// ----------------------------------------------------------------------------
// air_pkg
// Shared widths, constants and types of the adaptive interrupt rate core.
// ----------------------------------------------------------------------------
package air_pkg;

    // field widths
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned SCALE_W    = 3;
    localparam int unsigned FLAG_BIT   = 15;
    localparam int unsigned BASE_SHIFT = 8;

    // quotient bits kept: sizes above 2047 all map to the same value
    localparam int unsigned QW      = 11;
    localparam int unsigned DIV_STG = QW + 1;

    // mapped value (max 6656) and rounded result (max 26)
    localparam int unsigned MAP_W = 13;
    localparam int unsigned RES_W = 5;
    localparam int unsigned SUM_W = 17;
    localparam int unsigned SHF_W = 4;

    // piecewise map knees and offsets
    localparam logic [QW-1:0]    KNEE1   = QW'(360);
    localparam logic [QW-1:0]    KNEE2   = QW'(1152);
    localparam logic [QW-1:0]    KNEE3   = QW'(1920);
    localparam logic [MAP_W-1:0] OFS1    = MAP_W'(376);
    localparam logic [MAP_W-1:0] OFS2    = MAP_W'(2176);
    localparam logic [MAP_W-1:0] OFS3    = MAP_W'(4480);
    localparam logic [MAP_W-1:0] SAT_VAL = MAP_W'(6656);

    // word that rides along the pipeline
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              upd;
    } air_side_t;

    // clamped quotient
    typedef struct packed {
        logic [QW-1:0] quo;
        logic          sat;
    } air_quo_t;

endpackage

### src/air_div.sv
// ----------------------------------------------------------------------------
// air_div
// Pipelined restoring divider: an entry stage, then one quotient bit per
// stage, saturating once the quotient reaches 2^QW.
// ----------------------------------------------------------------------------
`include "adaptive_interrupt_rate_core_macros.svh"

module air_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [air_pkg::CNT_W-1:0]  in_dividend,
    input  logic [air_pkg::CNT_W-1:0]  in_divisor,
    input  air_pkg::air_side_t         in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output air_pkg::air_quo_t          out_quo,
    output air_pkg::air_side_t         out_side
);

    logic [air_pkg::DIV_STG-1:0] vld_reg;
    logic [air_pkg::DIV_STG-1:0] sat_reg;
    logic [air_pkg::CNT_W-1:0]   rem_reg  [air_pkg::DIV_STG];
    logic [air_pkg::CNT_W-1:0]   dvs_reg  [air_pkg::DIV_STG];
    logic [air_pkg::QW-1:0]      quo_reg  [air_pkg::DIV_STG];
    air_pkg::air_side_t          side_reg [air_pkg::DIV_STG];

    logic [air_pkg::CNT_W-1:0]   rem_next [air_pkg::DIV_STG];
    logic [air_pkg::QW-1:0]      quo_next [air_pkg::DIV_STG];
    logic                        sat_in;
    logic [air_pkg::DIV_STG:0]   adv;

    // stage advance: a stage loads when empty or when it drains
    always_comb begin
        adv[air_pkg::DIV_STG] = out_ready;
        for (int j = air_pkg::DIV_STG - 1; j >= 0; j--) begin
            adv[j] = !vld_reg[j] || adv[j+1];
        end
    end

    assign in_ready = adv[0];

    // quotient too large when dividend / 2^QW >= divisor
    assign sat_in = (in_dividend >> air_pkg::QW) >= in_divisor;

    // one trial subtract per stage, MSB of quotient first
    always_comb begin
        rem_next[0] = in_dividend;
        quo_next[0] = '0;
        for (int j = 1; j < air_pkg::DIV_STG; j++) begin
            automatic int   k  = air_pkg::DIV_STG - 1 - j;
            automatic logic ge = (rem_reg[j-1] >> k) >= dvs_reg[j-1];
            rem_next[j] = ge ? (rem_reg[j-1] - (dvs_reg[j-1] << k)) : rem_reg[j-1];
            quo_next[j] = {quo_reg[j-1][air_pkg::QW-2:0], ge};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int j = 1; j < air_pkg::DIV_STG; j++) begin
                if (adv[j]) begin
                    vld_reg[j] <= vld_reg[j-1];
                end
            end
        end
    end

    // stage data
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            dvs_reg[0]  <= in_divisor;
            sat_reg[0]  <= sat_in;
            side_reg[0] <= in_side;
        end
        for (int j = 1; j < air_pkg::DIV_STG; j++) begin
            if (adv[j]) begin
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
                dvs_reg[j]  <= dvs_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid   = vld_reg[air_pkg::DIV_STG-1];
    assign out_quo.quo = quo_reg[air_pkg::DIV_STG-1];
    assign out_quo.sat = sat_reg[air_pkg::DIV_STG-1];
    assign out_side    = side_reg[air_pkg::DIV_STG-1];

    // a finished, unsaturated division leaves a remainder below the divisor
    `AIR_ASSERT_IMP(a_rem_below_divisor, aclk, aresetn, vld_reg[air_pkg::DIV_STG-1] && !sat_reg[air_pkg::DIV_STG-1] && dvs_reg[air_pkg::DIV_STG-1] != '0, rem_reg[air_pkg::DIV_STG-1] < dvs_reg[air_pkg::DIV_STG-1])

endmodule

### src/air_map.sv
// ----------------------------------------------------------------------------
// air_map
// Piecewise-linear size map, then round-up shift by link scale and
// merge with the adaptive flag; two register stages.
// ----------------------------------------------------------------------------
`include "adaptive_interrupt_rate_core_macros.svh"

module air_map (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [air_pkg::SCALE_W-1:0] link_scale,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  air_pkg::air_quo_t           in_quo,
    input  air_pkg::air_side_t          in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [air_pkg::WORD_W-1:0]  out_word,
    output logic                        out_updated
);

    logic                         a_vld_reg;
    logic [air_pkg::MAP_W-1:0]    a_val_reg;
    air_pkg::air_side_t           a_side_reg;
    logic                         o_vld_reg;
    logic [air_pkg::WORD_W-1:0]   o_word_reg;
    logic                         o_upd_reg;

    logic                         adv_a;
    logic                         adv_o;
    logic [air_pkg::MAP_W-1:0]    size_w;
    logic [air_pkg::MAP_W-1:0]    a_val_next;
    logic [air_pkg::SHF_W-1:0]    shift;
    logic [air_pkg::SUM_W-1:0]    sum;
    logic [air_pkg::SUM_W-1:0]    shifted;
    logic [air_pkg::RES_W-1:0]    res;
    logic [air_pkg::WORD_W-1:0]   o_word_next;

    assign adv_o    = !o_vld_reg || out_ready;
    assign adv_a    = !a_vld_reg || adv_o;
    assign in_ready = adv_a;

    // size to interval value
    assign size_w = air_pkg::MAP_W'(in_quo.quo);
    always_comb begin
        if (in_quo.sat || in_quo.quo > air_pkg::KNEE3) begin
            a_val_next = air_pkg::SAT_VAL;
        end else if (in_quo.quo <= air_pkg::KNEE1) begin
            a_val_next = (size_w << 3) + air_pkg::OFS1;
        end else if (in_quo.quo <= air_pkg::KNEE2) begin
            a_val_next = (size_w << 1) + size_w + air_pkg::OFS2;
        end else begin
            a_val_next = size_w + air_pkg::OFS3;
        end
    end

    // round up: (val + 2^s - 1) >> s, s = scale + 8
    assign shift   = air_pkg::SHF_W'(link_scale) + air_pkg::SHF_W'(air_pkg::BASE_SHIFT);
    assign sum     = air_pkg::SUM_W'(a_val_reg)
                   + ((air_pkg::SUM_W'(1) << shift) - air_pkg::SUM_W'(1));
    assign shifted = sum >> shift;
    assign res     = shifted[air_pkg::RES_W-1:0];

    assign o_word_next = a_side_reg.upd
        ? (air_pkg::WORD_W'(res) | (air_pkg::WORD_W'(1) << air_pkg::FLAG_BIT))
        : a_side_reg.word;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                a_vld_reg <= in_valid;
            end
            if (adv_o) begin
                o_vld_reg <= a_vld_reg;
            end
        end
    end

    // stage data
    always_ff @(posedge aclk) begin
        if (adv_a) begin
            a_val_reg  <= a_val_next;
            a_side_reg <= in_side;
        end
        if (adv_o) begin
            o_word_reg <= o_word_next;
            o_upd_reg  <= a_side_reg.upd;
        end
    end

    assign out_valid   = o_vld_reg;
    assign out_word    = o_word_reg;
    assign out_updated = o_upd_reg;

    // mapped value always within the table's range
    `AIR_ASSERT_IMP(a_map_range, aclk, aresetn, a_vld_reg, a_val_reg >= air_pkg::OFS1 && a_val_reg <= air_pkg::SAT_VAL)

endmodule

### src/adaptive_interrupt_rate_core.sv
// ----------------------------------------------------------------------------
// adaptive_interrupt_rate_core
// Computes a new adaptive interrupt throttle word from one interval's byte
// and packet totals. Takes one word per cycle unless the result side
// stalls it. The 14 register stages are the divider's entry stage
// (oversized-quotient check), its 11 stages of one quotient bit each,
// the map stage and the output register. Backpressure on the result side
// stalls the pipeline without loss; empty stages still fill while it is
// stalled. link_scale is written over the cfg channel and takes effect on
// words that reach the rounding stage after it.
// ----------------------------------------------------------------------------
`include "adaptive_interrupt_rate_core_macros.svh"

module adaptive_interrupt_rate_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [air_pkg::SCALE_W-1:0] cfg_data,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [air_pkg::CNT_W-1:0]   s_byte_total,
    input  logic [air_pkg::CNT_W-1:0]   s_packet_total,
    input  logic [air_pkg::WORD_W-1:0]  s_current_rate_word,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [air_pkg::WORD_W-1:0]  m_new_rate_word,
    output logic                        m_was_updated
);

    logic [air_pkg::SCALE_W-1:0] scale_reg;
    air_pkg::air_side_t          s_side;
    logic                        d_valid;
    logic                        d_ready;
    air_pkg::air_quo_t           d_quo;
    air_pkg::air_side_t          d_side;

    // link scale register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            scale_reg <= cfg_data;
        end
    end

    // update only with adaptive flag set and some packets seen
    assign s_side.word = s_current_rate_word;
    assign s_side.upd  = s_current_rate_word[air_pkg::FLAG_BIT] && (s_packet_total != '0);

    air_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_dividend (s_byte_total),
        .in_divisor  (s_packet_total),
        .in_side     (s_side),
        .out_valid   (d_valid),
        .out_ready   (d_ready),
        .out_quo     (d_quo),
        .out_side    (d_side)
    );

    air_map u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .link_scale  (scale_reg),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_quo      (d_quo),
        .in_side     (d_side),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_word    (m_new_rate_word),
        .out_updated (m_was_updated)
    );

    // updated word carries the flag and a small interval value only
    `AIR_ASSERT_IMP(a_upd_word_form, aclk, aresetn, m_valid && m_was_updated, (m_new_rate_word >> air_pkg::RES_W) == (air_pkg::WORD_W'(1) << (air_pkg::FLAG_BIT - air_pkg::RES_W)))

    // input side only backs up when the result side is stalled
    `AIR_ASSERT_IMP(a_stall_source, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule
